[rtl/core/npgi_pkg.sv]
// shared types and constants of the nested prefix group indexer
`default_nettype none

package npgi_pkg;

  // field widths of the item queue, sized for the widest parameter settings, and the output count width
  localparam int MaxKeyBits   = 64;
  localparam int MaxRingBits  = 32;
  localparam int MaxCountBits = 64;
  localparam int OutCountBits = 48;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_FINISH = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_TOP    = 2'd0,
    KIND_RING1  = 2'd1,
    KIND_RING2  = 2'd2,
    KIND_RING34 = 2'd3
  } kind_e;

  // emission order of the records of one item, innermost first
  typedef enum logic [1:0] {
    STEP_RING34 = 2'd0,
    STEP_RING2  = 2'd1,
    STEP_RING1  = 2'd2,
    STEP_TOP    = 2'd3
  } step_e;

  // one classified item: which records to send and what they carry
  typedef struct packed {
    step_e                    first_step;
    step_e                    last_step;
    logic [MaxKeyBits-1:0]    occ_key;
    logic [MaxRingBits-1:0]   ring1_key;
    logic [MaxRingBits-1:0]   ring2_key;
    logic [MaxRingBits-1:0]   ring34_key;
    logic                     count_not_one;
    logic [MaxCountBits-1:0]  ring34_records;
    logic [MaxCountBits-1:0]  ring2_start;
    logic [MaxCountBits-1:0]  ring2_records;
    logic [MaxCountBits-1:0]  ring1_start;
    logic [MaxCountBits-1:0]  ring1_records;
  } entry_t;

endpackage

`default_nettype wire

[rtl/core/npgi_front.sv]
// front end: accepts key pairs, tracks open groups and classifies each item
`default_nettype none

module npgi_front #(
  parameter int KEY_BITS    = 64,
  parameter int RING1_BITS  = 28,
  parameter int RING2_BITS  = 20,
  parameter int RING34_BITS = 16,
  parameter int COUNT_BITS  = 48
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             opcode_i,
  input  wire logic [63:0]      occupancy_key_i,
  input  wire logic [63:0]      color_key_i,
  output logic                  push_valid_o,
  input  wire logic             push_ready_i,
  output npgi_pkg::entry_t      push_data_o
);
  import npgi_pkg::*;

  localparam int R1ShiftRaw = KEY_BITS - RING1_BITS;
  localparam int R2ShiftRaw = KEY_BITS - RING1_BITS - RING2_BITS;
  localparam int R1Shift    = (R1ShiftRaw < 0) ? 0 : R1ShiftRaw;
  localparam int R2Shift    = (R2ShiftRaw < 0) ? 0 : R2ShiftRaw;
  localparam logic [1:0] MembersOne = 2'd1;
  localparam logic [1:0] MembersTwo = 2'd2;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] x);
    return (x != {COUNT_BITS{1'b1}}) ? COUNT_BITS'(x + 1'b1) : x;
  endfunction

  logic                   valid_q, valid_d;
  logic [KEY_BITS-1:0]    occ_q, occ_d;
  logic [RING1_BITS-1:0]  ring1_q, ring1_d;
  logic [RING2_BITS-1:0]  ring2_q, ring2_d;
  logic [RING34_BITS-1:0] ring34_q, ring34_d;
  logic [1:0]             members_q, members_d;
  logic [COUNT_BITS-1:0]  ring1_start_q, ring1_start_d;
  logic [COUNT_BITS-1:0]  ring2_start_q, ring2_start_d;
  logic [COUNT_BITS-1:0]  rec1_q, rec1_d;
  logic [COUNT_BITS-1:0]  rec2_q, rec2_d;
  logic [COUNT_BITS-1:0]  rec34_q, rec34_d;

  logic [63:0]            occ_w, col_w, r1_w, r2_w;
  logic [KEY_BITS-1:0]    occ_m;
  logic [RING1_BITS-1:0]  r1;
  logic [RING2_BITS-1:0]  r2;
  logic [RING34_BITS-1:0] r34;
  logic                   is_finish, accept, has_rec;
  logic                   diff_occ, diff1, diff2, diff34;
  logic                   close1, close2, close34, top;
  logic                   open1, open2, open34;
  logic [COUNT_BITS-1:0]  rec1_n, rec2_n, rec34_n;

  // keys masked to key width; ring1, ring2 top down, ring34 at the bottom
  assign occ_w = occupancy_key_i & (64'hffff_ffff_ffff_ffff >> (64 - KEY_BITS));
  assign col_w = color_key_i & (64'hffff_ffff_ffff_ffff >> (64 - KEY_BITS));
  assign occ_m = occ_w[KEY_BITS-1:0];
  assign r1_w  = col_w >> R1Shift;
  assign r2_w  = col_w >> R2Shift;
  assign r1    = r1_w[RING1_BITS-1:0];
  assign r2    = r2_w[RING2_BITS-1:0];
  assign r34   = col_w[RING34_BITS-1:0];

  assign is_finish = (opcode_e'(opcode_i) == OP_FINISH);
  assign accept    = in_valid_i & push_ready_i;
  assign in_ready_o = push_ready_i;

  assign diff_occ = (occ_m != occ_q);
  assign diff1    = (r1 != ring1_q);
  assign diff2    = (r2 != ring2_q);
  assign diff34   = (r34 != ring34_q);

  // all levels open together on the first item and close together on finish
  assign close1  = valid_q & (is_finish | diff_occ | diff1);
  assign close2  = valid_q & (is_finish | diff_occ | diff1 | diff2);
  assign close34 = valid_q & (is_finish | diff_occ | diff1 | diff2 | diff34);
  assign top     = ~is_finish & (~valid_q | diff_occ);
  assign open1   = ~valid_q | diff_occ | diff1;
  assign open2   = open1 | diff2;
  assign open34  = open2 | diff34;
  assign has_rec = close34 | top;

  assign rec34_n = close34 ? sat_inc(rec34_q) : rec34_q;
  assign rec2_n  = close2  ? sat_inc(rec2_q)  : rec2_q;
  assign rec1_n  = close1  ? sat_inc(rec1_q)  : rec1_q;

  always_comb begin
    push_data_o.first_step     = close34 ? STEP_RING34 : STEP_TOP;
    push_data_o.last_step      = top    ? STEP_TOP   :
                                 close1 ? STEP_RING1 :
                                 close2 ? STEP_RING2 : STEP_RING34;
    push_data_o.occ_key        = MaxKeyBits'(occ_m);
    push_data_o.ring1_key      = MaxRingBits'(ring1_q);
    push_data_o.ring2_key      = MaxRingBits'(ring2_q);
    push_data_o.ring34_key     = MaxRingBits'(ring34_q);
    push_data_o.count_not_one  = (members_q != MembersOne);
    push_data_o.ring34_records = MaxCountBits'(rec34_n);
    push_data_o.ring2_start    = MaxCountBits'(ring2_start_q);
    push_data_o.ring2_records  = MaxCountBits'(rec2_n);
    push_data_o.ring1_start    = MaxCountBits'(ring1_start_q);
    push_data_o.ring1_records  = MaxCountBits'(rec1_n);
  end

  assign push_valid_o = accept & has_rec;

  always_comb begin
    valid_d       = valid_q;
    occ_d         = occ_q;
    ring1_d       = ring1_q;
    ring2_d       = ring2_q;
    ring34_d      = ring34_q;
    members_d     = members_q;
    ring1_start_d = ring1_start_q;
    ring2_start_d = ring2_start_q;
    rec1_d        = rec1_q;
    rec2_d        = rec2_q;
    rec34_d       = rec34_q;
    if (accept) begin
      if (is_finish) begin
        valid_d       = 1'b0;
        occ_d         = '0;
        ring1_d       = '0;
        ring2_d       = '0;
        ring34_d      = '0;
        members_d     = '0;
        ring1_start_d = '0;
        ring2_start_d = '0;
        rec1_d        = '0;
        rec2_d        = '0;
        rec34_d       = '0;
      end else begin
        valid_d = 1'b1;
        occ_d   = occ_m;
        rec1_d  = rec1_n;
        rec2_d  = rec2_n;
        rec34_d = rec34_n;
        if (open1) begin
          ring1_d       = r1;
          ring1_start_d = rec2_n;
        end
        if (open2) begin
          ring2_d       = r2;
          ring2_start_d = rec34_n;
        end
        if (open34) begin
          ring34_d  = r34;
          members_d = MembersOne;
        end else if (members_q != MembersTwo) begin
          members_d = members_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= 1'b0;
      occ_q         <= '0;
      ring1_q       <= '0;
      ring2_q       <= '0;
      ring34_q      <= '0;
      members_q     <= '0;
      ring1_start_q <= '0;
      ring2_start_q <= '0;
      rec1_q        <= '0;
      rec2_q        <= '0;
      rec34_q       <= '0;
    end else begin
      valid_q       <= valid_d;
      occ_q         <= occ_d;
      ring1_q       <= ring1_d;
      ring2_q       <= ring2_d;
      ring34_q      <= ring34_d;
      members_q     <= members_d;
      ring1_start_q <= ring1_start_d;
      ring2_start_q <= ring2_start_d;
      rec1_q        <= rec1_d;
      rec2_q        <= rec2_d;
      rec34_q       <= rec34_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/npgi_queue.sv]
// two-entry queue of classified items between front and back end
`default_nettype none

module npgi_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  npgi_pkg::entry_t      push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output npgi_pkg::entry_t      pop_data_o
);
  import npgi_pkg::*;

  localparam int Depth   = 2;
  localparam int PtrBits = $clog2(Depth);
  localparam int CntBits = $clog2(Depth + 1);

  entry_t               slots_q [Depth];
  logic [PtrBits-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0]   count_q;
  logic                 do_push, do_pop;

  assign push_ready_o = (count_q != CntBits'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slots_q[rd_ptr_q];
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : PtrBits'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : PtrBits'(rd_ptr_q + 1'b1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= CntBits'(count_q + 1'b1);
        2'b01:   count_q <= CntBits'(count_q - 1'b1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/npgi_back.sv]
// back end: turns each queued item into its records, one record a cycle while the output is not stalled
`default_nettype none

module npgi_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             pop_valid_i,
  output logic                  pop_ready_o,
  input  npgi_pkg::entry_t      pop_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [1:0]            record_kind_o,
  output logic [63:0]           key_value_o,
  output logic [47:0]           member_count_o,
  output logic [47:0]           child_offset_o,
  output logic                  count_not_one_o,
  output logic                  last_o
);
  import npgi_pkg::*;

  logic                    started_q, started_d;
  step_e                   step_q, step_d;
  step_e                   cur_step, next_step;
  logic                    produce, is_last;
  logic                    out_valid_q, out_valid_d;
  kind_e                   kind_q, kind_d;
  logic [63:0]             key_q, key_d;
  logic [OutCountBits-1:0] cnt_q, cnt_d, off_q, off_d;
  logic                    cno_q, cno_d, last_q;
  logic [MaxCountBits-1:0] diff2, diff1;

  assign cur_step = started_q ? step_q : pop_data_i.first_step;
  assign produce  = pop_valid_i & (~out_valid_q | out_ready_i);
  assign is_last  = (cur_step == pop_data_i.last_step);
  assign pop_ready_o = produce & is_last;

  assign diff2 = pop_data_i.ring34_records - pop_data_i.ring2_start;
  assign diff1 = pop_data_i.ring2_records - pop_data_i.ring1_start;

  always_comb begin
    case (cur_step)
      STEP_RING34: next_step = STEP_RING2;
      STEP_RING2:  next_step = STEP_RING1;
      STEP_RING1:  next_step = STEP_TOP;
      default:     next_step = STEP_TOP;
    endcase
  end

  always_comb begin
    kind_d = KIND_TOP;
    key_d  = pop_data_i.occ_key;
    cnt_d  = '0;
    off_d  = pop_data_i.ring1_records[OutCountBits-1:0];
    cno_d  = 1'b0;
    case (cur_step)
      STEP_RING34: begin
        kind_d = KIND_RING34;
        key_d  = 64'(pop_data_i.ring34_key);
        off_d  = '0;
        cno_d  = pop_data_i.count_not_one;
      end
      STEP_RING2: begin
        kind_d = KIND_RING2;
        key_d  = 64'(pop_data_i.ring2_key);
        cnt_d  = diff2[OutCountBits-1:0];
        off_d  = pop_data_i.ring2_start[OutCountBits-1:0];
      end
      STEP_RING1: begin
        kind_d = KIND_RING1;
        key_d  = 64'(pop_data_i.ring1_key);
        cnt_d  = diff1[OutCountBits-1:0];
        off_d  = pop_data_i.ring1_start[OutCountBits-1:0];
      end
      default: begin
        kind_d = KIND_TOP;
      end
    endcase
  end

  always_comb begin
    started_d   = started_q;
    step_d      = step_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    if (produce) begin
      out_valid_d = 1'b1;
      started_d   = ~is_last;
      step_d      = next_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      step_q      <= STEP_RING34;
      out_valid_q <= 1'b0;
    end else begin
      started_q   <= started_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      kind_q <= kind_d;
      key_q  <= key_d;
      cnt_q  <= cnt_d;
      off_q  <= off_d;
      cno_q  <= cno_d;
      last_q <= is_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign record_kind_o   = kind_q;
  assign key_value_o     = key_q;
  assign member_count_o  = cnt_q;
  assign child_offset_o  = off_q;
  assign count_not_one_o = cno_q;
  assign last_o          = last_q;

endmodule

`default_nettype wire

[rtl/core/nested_prefix_group_indexer.sv]
// top level of the nested prefix group indexer
`default_nettype none

// takes a sorted stream of (occupancy, colour) key pairs and emits index
// records as nested groups close: ring34, ring2, ring1, then a top record
// when a new occupancy starts. the front end accepts one item every cycle
// while its two-entry item queue has room; a repeated key pair produces no
// record and leaves the queue untouched. the back end sends one record per
// cycle from its output register while the output is not stalled, so an
// item that causes one to four records holds the back end until its last
// record is loaded into the output register. an accepted item passes through
// the queue slot and the back end output register before its first record
// appears. finish closes all open groups and returns the front end to its reset state.

module nested_prefix_group_indexer #(
  parameter int KEY_BITS    = 64,
  parameter int RING1_BITS  = 28,
  parameter int RING2_BITS  = 20,
  parameter int RING34_BITS = 16,
  parameter int COUNT_BITS  = 48
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // input items
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // occupancy_key[63:0], color_key[127:64]
  input  wire logic [0:0]   s_axis_tuser,  // opcode[0]
  // result items
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [167:0]      m_axis_tdata,  // key_value[63:0], member_count[111:64],
                                           // child_offset[159:112], count_not_one[160],
                                           // zero fill[167:161]
  output logic [1:0]        m_axis_tuser,  // record_kind[1:0]
  output logic              m_axis_tlast   // last record of the item
);
  import npgi_pkg::*;

  // classified items crossing from front to back
  logic   push_valid, push_ready;
  entry_t push_data;
  logic   pop_valid, pop_ready;
  entry_t pop_data;

  // unpacked result fields
  logic [1:0]  record_kind;
  logic [63:0] key_value;
  logic [47:0] member_count, child_offset;
  logic        count_not_one;

  // group tracking and classification, one item per cycle while the queue has room
  npgi_front #(
    .KEY_BITS    (KEY_BITS),
    .RING1_BITS  (RING1_BITS),
    .RING2_BITS  (RING2_BITS),
    .RING34_BITS (RING34_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .opcode_i        (s_axis_tuser[0]),
    .occupancy_key_i (s_axis_tdata[63:0]),
    .color_key_i     (s_axis_tdata[127:64]),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_data_o     (push_data)
  );

  // decouples the two sides so either may stall alone
  npgi_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // record sequencer with registered output
  npgi_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .pop_data_i      (pop_data),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .record_kind_o   (record_kind),
    .key_value_o     (key_value),
    .member_count_o  (member_count),
    .child_offset_o  (child_offset),
    .count_not_one_o (count_not_one),
    .last_o          (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, count_not_one, child_offset, member_count, key_value};
  assign m_axis_tuser = record_kind;

endmodule

`default_nettype wire
